// ===== rtl/bcc_pkg.sv =====
package bcc_pkg;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [1:0] REG_PRESSED_LEVEL = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS    = 2'd1;
  localparam logic [1:0] REG_DOUBLE_WAIT   = 2'd2;

  localparam logic [7:0] LONG_TICKS_RESET  = 8'd30;
  localparam logic [7:0] DOUBLE_WAIT_RESET = 8'd15;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } click_event_e;

  typedef struct packed {
    logic       pressed_level;
    logic [7:0] long_press_ticks;
    logic [7:0] double_wait_ticks;
  } cfg_t;

endpackage

// ===== rtl/bcc_cfg.sv =====
module bcc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bcc_pkg::cfg_t      cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        bcc_pkg::REG_PRESSED_LEVEL: cfg_d.pressed_level     = pwdata[0];
        bcc_pkg::REG_LONG_TICKS:    cfg_d.long_press_ticks  = pwdata[7:0];
        bcc_pkg::REG_DOUBLE_WAIT:   cfg_d.double_wait_ticks = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcc_pkg::REG_PRESSED_LEVEL: prdata = {31'd0, cfg_q.pressed_level};
      bcc_pkg::REG_LONG_TICKS:    prdata = {24'd0, cfg_q.long_press_ticks};
      bcc_pkg::REG_DOUBLE_WAIT:   prdata = {24'd0, cfg_q.double_wait_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressed_level     <= 1'b0;
      cfg_q.long_press_ticks  <= bcc_pkg::LONG_TICKS_RESET;
      cfg_q.double_wait_ticks <= bcc_pkg::DOUBLE_WAIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/button_click_classifier.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o   pin_level_i (1 bit)
// result    out        out_valid_o/out_stall_i click_event_o (2 bits)
// config    in         APB psel/penable        paddr/pwdata/prdata
//
// One request enters the input register per cycle while in_stall_o is low; its event is
// then loaded into the result register while the next request enters the input register.
// The phase and tick counter update in the same cycle that the result register loads.
// Reset clears the phase, the counter, both valid flags and loads the register defaults.
// A stall on the result side holds the result and backs up into the input register.
module button_click_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  click_event_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_PRESSED  = 3'd2;
  localparam logic [2:0] PH_LONG     = 3'd3;
  localparam logic [2:0] PH_WAIT     = 3'd4;
  localparam logic [2:0] PH_SECOND   = 3'd5;

  bcc_pkg::cfg_t        cfg;
  logic                 in_valid_q;
  logic                 pin_q;
  logic                 out_valid_q;
  bcc_pkg::click_event_e event_q, event_d;
  logic [2:0]           phase_q, phase_d;
  logic [7:0]           tick_q, tick_d;
  logic                 advance;
  logic                 step;
  logic                 pressed;
  logic                 long_hit;
  logic                 wait_hit;

  bcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register can take a new value when it is empty or being drained.
  assign advance    = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;

  assign pressed  = (pin_q == cfg.pressed_level);
  assign long_hit = (tick_q >= cfg.long_press_ticks);
  assign wait_hit = (tick_q >= cfg.double_wait_ticks);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    event_d = bcc_pkg::EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (pressed) phase_d = PH_DEBOUNCE;
        else         tick_d  = 8'd0;
      end
      PH_DEBOUNCE: begin
        if (pressed) begin
          phase_d = PH_PRESSED;
        end else begin
          phase_d = PH_IDLE;
          tick_d  = 8'd0;
        end
      end
      PH_PRESSED: begin
        if (pressed && long_hit) begin
          phase_d = PH_LONG;
          tick_d  = 8'd0;
        end else if (pressed) begin
          tick_d = tick_q + 8'd1;
        end else begin
          phase_d = PH_WAIT;
          tick_d  = 8'd0;
        end
      end
      PH_LONG: begin
        tick_d = 8'd0;
        if (!pressed) begin
          phase_d = PH_IDLE;
          event_d = bcc_pkg::EV_LONG;
        end
      end
      PH_WAIT: begin
        if (!pressed && wait_hit) begin
          phase_d = PH_IDLE;
          tick_d  = 8'd0;
          event_d = bcc_pkg::EV_SINGLE;
        end else if (!pressed) begin
          tick_d = tick_q + 8'd1;
        end else begin
          phase_d = PH_SECOND;
          tick_d  = 8'd0;
        end
      end
      PH_SECOND: begin
        if (pressed && long_hit) begin
          phase_d = PH_IDLE;
          tick_d  = 8'd0;
          event_d = bcc_pkg::EV_SINGLE;
        end else if (pressed) begin
          tick_d = tick_q + 8'd1;
        end else begin
          phase_d = PH_IDLE;
          tick_d  = 8'd0;
          event_d = bcc_pkg::EV_DOUBLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      tick_q      <= 8'd0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance)     out_valid_q <= in_valid_q;
      if (step) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) pin_q <= pin_level_i;
    if (step) event_q <= event_d;
  end

  assign out_valid_o   = out_valid_q;
  assign click_event_o = event_q;

endmodule
